@@ rtl/iseg_pkg.sv @@
// ----------------------------------------------------------------------------
// iseg_pkg
// Shared types, codes and helpers of the input sample event generator.
// ----------------------------------------------------------------------------
`default_nettype none

package iseg_pkg;

    localparam int KEY_BUTTONS_DEFAULT = 6;
    localparam int NUM_KEY_REGS        = 6;
    localparam int KEY_IDX_W           = 3;
    localparam int CFG_IDX_W           = 3;
    localparam int KEY_CODE_W          = 8;

    // Fixed event slots in emission order; key slots follow from SLOT_KEY0.
    localparam int SLOT_MOTION = 0;
    localparam int SLOT_BTN_L  = 1;
    localparam int SLOT_BTN_R  = 3;
    localparam int SLOT_WHEEL  = 4;
    localparam int SLOT_AXIS_X = 5;
    localparam int SLOT_AXIS_Y = 6;
    localparam int SLOT_KEY0   = 7;

    localparam logic signed [15:0] AXIS_FULL = 16'sd32767;

    typedef logic [NUM_KEY_REGS-1:0][KEY_CODE_W-1:0] key_map_t;

    localparam key_map_t KEY_MAP_RESET = {8'd27, 8'd114, 8'd122, 8'd116, 8'd99, 8'd105};

    typedef enum logic [2:0] {
        EV_MOTION   = 3'd0,
        EV_BTN_DOWN = 3'd1,
        EV_BTN_UP   = 3'd2,
        EV_WHEEL    = 3'd3,
        EV_AXIS     = 3'd4,
        EV_KEY_DOWN = 3'd5,
        EV_KEY_UP   = 3'd6
    } event_kind_t;

    typedef enum logic [1:0] {
        AXIS_CENTER = 2'd0,
        AXIS_POS    = 2'd1,
        AXIS_NEG    = 2'd2
    } axis_dir_t;

    // Everything the event picker needs from one sample
    typedef struct packed {
        logic signed [15:0]     pos_x;
        logic signed [15:0]     pos_y;
        logic signed [16:0]     rel_x;
        logic signed [16:0]     rel_y;
        logic [2:0]             button_mask;
        logic [2:0]             btn_down;
        logic signed [7:0]      wheel;
        axis_dir_t              axis_x;
        axis_dir_t              axis_y;
        logic [NUM_KEY_REGS-1:0] key_down;
    } item_info_t;

    function automatic axis_dir_t dir_code(input logic plus, input logic minus);
        axis_dir_t d;
        begin
            if (plus && !minus)
            begin
                d = AXIS_POS;
            end
            else if (minus && !plus)
            begin
                d = AXIS_NEG;
            end
            else
            begin
                d = AXIS_CENTER;
            end
            return d;
        end
    endfunction

    function automatic logic signed [15:0] axis_value(input axis_dir_t d);
        logic signed [15:0] v;
        begin
            case (d)
                AXIS_POS: v = AXIS_FULL;
                AXIS_NEG: v = -AXIS_FULL;
                default:  v = 16'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/iseg_detect.sv @@
// ----------------------------------------------------------------------------
// iseg_detect
// Compares one sample against the previous one and flags the events it raises.
// ----------------------------------------------------------------------------
`default_nettype none

module iseg_detect #(
    parameter int KEY_BUTTONS = iseg_pkg::KEY_BUTTONS_DEFAULT,
    parameter int NUM_SLOTS   = iseg_pkg::SLOT_KEY0 + KEY_BUTTONS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic signed [15:0]       mouse_x,
    input  wire logic signed [15:0]       mouse_y,
    input  wire logic [2:0]               mouse_buttons,
    input  wire logic signed [7:0]        wheel_delta,
    input  wire logic [9:0]               pad_bits,
    input  wire logic                     osk_active,
    output logic [NUM_SLOTS-1:0]          slots,
    output iseg_pkg::item_info_t          info
);

    logic signed [15:0]   prev_x_reg;
    logic signed [15:0]   prev_y_reg;
    logic [2:0]           prev_mask_reg;
    iseg_pkg::axis_dir_t  axis_x_reg;
    iseg_pkg::axis_dir_t  axis_y_reg;
    logic [9:0]           prev_pad_reg;

    logic [2:0]             mask;
    logic [2:0]             btn_ev;
    logic                   motion;
    iseg_pkg::axis_dir_t    ax;
    iseg_pkg::axis_dir_t    ay;
    logic [KEY_BUTTONS-1:0] key_now;
    logic [KEY_BUTTONS-1:0] key_prev;
    logic [KEY_BUTTONS-1:0] key_ev;

    always_comb
    begin
        // remap to bit0 left, bit1 middle, bit2 right
        mask     = {mouse_buttons[1], mouse_buttons[2], mouse_buttons[0]};
        btn_ev   = mask ^ prev_mask_reg;
        motion   = (mouse_x != prev_x_reg) || (mouse_y != prev_y_reg);
        ax       = iseg_pkg::dir_code(pad_bits[3], pad_bits[2]);
        ay       = iseg_pkg::dir_code(pad_bits[1], pad_bits[0]);
        key_now  = pad_bits[4 +: KEY_BUTTONS];
        key_prev = prev_pad_reg[4 +: KEY_BUTTONS];
        key_ev   = osk_active ? '0 : (key_now ^ key_prev);

        slots = {key_ev, (ay != axis_y_reg), (ax != axis_x_reg), (wheel_delta != 8'sd0),
                 btn_ev, motion};

        info.pos_x       = mouse_x;
        info.pos_y       = mouse_y;
        info.rel_x       = {mouse_x[15], mouse_x} - {prev_x_reg[15], prev_x_reg};
        info.rel_y       = {mouse_y[15], mouse_y} - {prev_y_reg[15], prev_y_reg};
        info.button_mask = mask;
        info.btn_down    = mask & ~prev_mask_reg;
        info.wheel       = wheel_delta;
        info.axis_x      = ax;
        info.axis_y      = ay;
        info.key_down    = '0;
        for (int i = 0; i < KEY_BUTTONS; i++)
        begin
            info.key_down[i] = key_now[i] & ~key_prev[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_mask_reg <= '0;
            axis_x_reg    <= iseg_pkg::AXIS_CENTER;
            axis_y_reg    <= iseg_pkg::AXIS_CENTER;
            prev_pad_reg  <= '0;
        end
        else if (accept)
        begin
            prev_x_reg    <= mouse_x;
            prev_y_reg    <= mouse_y;
            prev_mask_reg <= mask;
            axis_x_reg    <= ax;
            axis_y_reg    <= ay;
            // track pad even while keyboard is up, so no stale edges later
            prev_pad_reg  <= pad_bits;
        end
    end

endmodule

`default_nettype wire

@@ rtl/iseg_emit.sv @@
// ----------------------------------------------------------------------------
// iseg_emit
// Holds one item's flagged events, sending one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module iseg_emit #(
    parameter int NUM_SLOTS = iseg_pkg::SLOT_KEY0 + iseg_pkg::KEY_BUTTONS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic [NUM_SLOTS-1:0] slots,
    input  wire iseg_pkg::item_info_t info,
    input  wire iseg_pkg::key_map_t   key_map,
    output logic                      free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [95:0]               m_tdata,
    output logic [2:0]                m_tuser,
    output logic                      m_tlast
);

    localparam int IdxW = $clog2(NUM_SLOTS);
    localparam int KeyIdxW = iseg_pkg::KEY_IDX_W;

    logic [NUM_SLOTS-1:0]  pend_reg;
    logic [NUM_SLOTS-1:0]  pend_next;
    iseg_pkg::item_info_t  info_reg;

    logic                  tvalid_reg;
    iseg_pkg::event_kind_t kind_reg;
    iseg_pkg::event_kind_t kind_next;
    logic signed [15:0]    pos_x_reg, pos_x_next;
    logic signed [15:0]    pos_y_reg, pos_y_next;
    logic signed [16:0]    rel_x_reg, rel_x_next;
    logic signed [16:0]    rel_y_reg, rel_y_next;
    logic [2:0]            mask_reg, mask_next;
    logic [7:0]            which_reg, which_next;
    logic signed [15:0]    amount_reg, amount_next;
    logic                  last_reg;

    logic                  advance;
    logic [NUM_SLOTS-1:0]  first;
    logic [NUM_SLOTS-1:0]  rest;
    logic [NUM_SLOTS-1:0]  pend_after;
    logic [IdxW-1:0]       idx;
    logic [KeyIdxW-1:0]    kidx;
    logic [1:0]            bidx;

    always_comb
    begin
        advance    = !tvalid_reg || m_tready;
        first      = pend_reg & (~pend_reg + 1'b1);
        rest       = pend_reg & ~first;
        pend_after = advance ? rest : pend_reg;
        free       = (pend_after == '0);
        pend_next  = load ? slots : pend_after;

        idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (first[i])
            begin
                idx = IdxW'(i);
            end
        end
        kidx = KeyIdxW'(idx - IdxW'(iseg_pkg::SLOT_KEY0));
        bidx = 2'(idx - IdxW'(iseg_pkg::SLOT_BTN_L));

        kind_next   = iseg_pkg::EV_MOTION;
        pos_x_next  = '0;
        pos_y_next  = '0;
        rel_x_next  = '0;
        rel_y_next  = '0;
        mask_next   = '0;
        which_next  = '0;
        amount_next = '0;
        case (idx) inside
            iseg_pkg::SLOT_MOTION:
            begin
                kind_next  = iseg_pkg::EV_MOTION;
                pos_x_next = info_reg.pos_x;
                pos_y_next = info_reg.pos_y;
                rel_x_next = info_reg.rel_x;
                rel_y_next = info_reg.rel_y;
                mask_next  = info_reg.button_mask;
            end
            [iseg_pkg::SLOT_BTN_L:iseg_pkg::SLOT_BTN_R]:
            begin
                kind_next  = info_reg.btn_down[bidx] ? iseg_pkg::EV_BTN_DOWN
                                                     : iseg_pkg::EV_BTN_UP;
                pos_x_next = info_reg.pos_x;
                pos_y_next = info_reg.pos_y;
                // slot number doubles as button id 1 left, 2 middle, 3 right
                which_next = 8'(idx);
            end
            iseg_pkg::SLOT_WHEEL:
            begin
                kind_next   = iseg_pkg::EV_WHEEL;
                pos_x_next  = info_reg.pos_x;
                pos_y_next  = info_reg.pos_y;
                amount_next = 16'(info_reg.wheel);
            end
            iseg_pkg::SLOT_AXIS_X:
            begin
                kind_next   = iseg_pkg::EV_AXIS;
                which_next  = 8'd0;
                amount_next = iseg_pkg::axis_value(info_reg.axis_x);
            end
            iseg_pkg::SLOT_AXIS_Y:
            begin
                kind_next   = iseg_pkg::EV_AXIS;
                which_next  = 8'd1;
                amount_next = iseg_pkg::axis_value(info_reg.axis_y);
            end
            default:
            begin
                kind_next  = info_reg.key_down[kidx] ? iseg_pkg::EV_KEY_DOWN
                                                     : iseg_pkg::EV_KEY_UP;
                which_next = key_map[kidx];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (advance)
            begin
                tvalid_reg <= |pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            info_reg <= info;
        end
        if (advance)
        begin
            kind_reg   <= kind_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            rel_x_reg  <= rel_x_next;
            rel_y_reg  <= rel_y_next;
            mask_reg   <= mask_next;
            which_reg  <= which_next;
            amount_reg <= amount_next;
            last_reg   <= (rest == '0);
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, amount_reg, which_reg, mask_reg, rel_y_reg, rel_x_reg,
                       pos_y_reg, pos_x_reg};

endmodule

`default_nettype wire

@@ rtl/input_sample_event_generator.sv @@
// ----------------------------------------------------------------------------
// input_sample_event_generator
// Turns per-frame input samples into an ordered stream of input events.
// ----------------------------------------------------------------------------
// Usage: one sample enters on the s_ channel; its events leave on the m_
// channel in fixed order (motion, buttons L/M/R, wheel, axis X, axis Y, keys),
// one per cycle, m_tlast set on the final event of the sample. A sample that
// changes nothing produces no event and is still taken.
// The first event of a sample moves from the pending-event register into
// the output register before it can be taken. A sample raises at most
// 7 + KEY_BUTTONS events; the next sample is taken in the cycle the last
// pending event moves into the output register, so samples with a single
// event or none flow at one per cycle while m_tready is high. The event
// holding register sets this pace.
// The keymap is written through cfg_we/cfg_index/cfg_data while idle.
// Reset clears the previous-sample state, restores the default keymap and
// empties the output. While m_tready is low the output holds its event and
// pending events wait; s_tready drops once the holding register is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module input_sample_event_generator #(
    parameter int KEY_BUTTONS = iseg_pkg::KEY_BUTTONS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mouse_x, mouse_y, mouse_buttons, wheel_delta, pad_bits, osk_active
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pos_x, pos_y, rel_x, rel_y, button_mask, which, amount
    output logic [95:0]      m_tdata,
    // event_kind
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [iseg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iseg_pkg::KEY_CODE_W-1:0] cfg_data
);

    localparam int NumSlots = iseg_pkg::SLOT_KEY0 + KEY_BUTTONS;

    iseg_pkg::key_map_t   key_map_reg;
    iseg_pkg::item_info_t info;
    logic [NumSlots-1:0]  slots;
    logic                 free;
    logic                 accept;

    assign s_tready = free;
    assign accept   = s_tvalid && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_map_reg <= iseg_pkg::KEY_MAP_RESET;
        end
        else if (cfg_we && (cfg_index < iseg_pkg::CFG_IDX_W'(iseg_pkg::NUM_KEY_REGS)))
        begin
            key_map_reg[cfg_index] <= cfg_data;
        end
    end

    iseg_detect #(
        .KEY_BUTTONS (KEY_BUTTONS),
        .NUM_SLOTS   (NumSlots)
    ) u_detect (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .mouse_x       (s_tdata[15:0]),
        .mouse_y       (s_tdata[31:16]),
        .mouse_buttons (s_tdata[34:32]),
        .wheel_delta   (s_tdata[42:35]),
        .pad_bits      (s_tdata[52:43]),
        .osk_active    (s_tdata[53]),
        .slots         (slots),
        .info          (info)
    );

    iseg_emit #(
        .NUM_SLOTS (NumSlots)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .slots    (slots),
        .info     (info),
        .key_map  (key_map_reg),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ verif/iseg_checker.sv @@
// ----------------------------------------------------------------------------
// iseg_checker
// Watches the sample, event and keymap ports of the input sample event
// generator. It predicts the ordered events of every accepted sample and
// compares each delivered event, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module iseg_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // mouse_x, mouse_y, mouse_buttons, wheel_delta, pad_bits, osk_active
    input  wire logic [55:0]                   s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // pos_x, pos_y, rel_x, rel_y, button_mask, which, amount
    input  wire logic [95:0]                   m_tdata,
    // event_kind
    input  wire logic [2:0]                    m_tuser,
    input  wire logic                          m_tlast,
    input  wire logic                          cfg_we,
    input  wire logic [iseg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iseg_pkg::KEY_CODE_W-1:0] cfg_data,
    output int                                 err_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        iseg_pkg::event_kind_t kind;
        logic signed [15:0]    pos_x;
        logic signed [15:0]    pos_y;
        logic signed [16:0]    rel_x;
        logic signed [16:0]    rel_y;
        logic [2:0]            mask;
        logic [7:0]            which;
        logic signed [15:0]    amount;
        logic                  last;
    } input_event_t;

    input_event_t expected_events[$];

    iseg_pkg::key_map_t  key_codes;
    logic [15:0]         prev_x;
    logic [15:0]         prev_y;
    logic [2:0]          prev_mask;
    iseg_pkg::axis_dir_t prev_axis_x;
    iseg_pkg::axis_dir_t prev_axis_y;
    logic [9:0]          prev_pad;

    function automatic input_event_t make_event(
        input iseg_pkg::event_kind_t kind,
        input logic signed [15:0]    px,
        input logic signed [15:0]    py,
        input logic signed [16:0]    rx,
        input logic signed [16:0]    ry,
        input logic [2:0]            mask,
        input logic [7:0]            which,
        input logic signed [15:0]    amount
    );
        input_event_t ev;
        ev.kind   = kind;
        ev.pos_x  = px;
        ev.pos_y  = py;
        ev.rel_x  = rx;
        ev.rel_y  = ry;
        ev.mask   = mask;
        ev.which  = which;
        ev.amount = amount;
        ev.last   = 1'b0;
        return ev;
    endfunction

    // opposite directions held together cancel to center
    function automatic iseg_pkg::axis_dir_t pad_direction(input logic plus, input logic minus);
        iseg_pkg::axis_dir_t d;
        case ({plus, minus})
            2'b10:   d = iseg_pkg::AXIS_POS;
            2'b01:   d = iseg_pkg::AXIS_NEG;
            default: d = iseg_pkg::AXIS_CENTER;
        endcase
        return d;
    endfunction

    function automatic logic signed [15:0] axis_amount(input iseg_pkg::axis_dir_t d);
        logic signed [15:0] v;
        v = 16'sd0;
        if (d == iseg_pkg::AXIS_POS)
        begin
            v = iseg_pkg::AXIS_FULL;
        end
        else if (d == iseg_pkg::AXIS_NEG)
        begin
            v = -iseg_pkg::AXIS_FULL;
        end
        return v;
    endfunction

    task automatic predict_sample(input logic [55:0] d);
        logic signed [15:0]  x;
        logic signed [15:0]  y;
        logic [2:0]          cb;
        logic [2:0]          mask;
        logic [2:0]          down;
        logic [2:0]          up;
        logic signed [7:0]   wheel;
        logic [9:0]          pad;
        logic                osk;
        iseg_pkg::axis_dir_t ax;
        iseg_pkg::axis_dir_t ay;
        input_event_t        batch[$];
        x     = d[15:0];
        y     = d[31:16];
        cb    = d[34:32];
        wheel = d[42:35];
        pad   = d[52:43];
        osk   = d[53];
        // input order is L, R, M; events use L, M, R
        mask  = {cb[1], cb[2], cb[0]};

        if (x != prev_x || y != prev_y)
        begin
            batch.push_back(make_event(iseg_pkg::EV_MOTION, x, y,
                {x[15], x} - {prev_x[15], prev_x},
                {y[15], y} - {prev_y[15], prev_y},
                mask, 8'd0, 16'sd0));
        end

        down = mask & ~prev_mask;
        up   = prev_mask & ~mask;
        for (int i = 0; i < 3; i++)
        begin
            if (down[i])
            begin
                batch.push_back(make_event(iseg_pkg::EV_BTN_DOWN, x, y, 17'sd0, 17'sd0,
                    3'd0, 8'(i + 1), 16'sd0));
            end
            else if (up[i])
            begin
                batch.push_back(make_event(iseg_pkg::EV_BTN_UP, x, y, 17'sd0, 17'sd0,
                    3'd0, 8'(i + 1), 16'sd0));
            end
        end

        if (wheel != 8'sd0)
        begin
            batch.push_back(make_event(iseg_pkg::EV_WHEEL, x, y, 17'sd0, 17'sd0, 3'd0,
                8'd0, wheel));
        end

        prev_x    = x;
        prev_y    = y;
        prev_mask = mask;

        ax = pad_direction(pad[3], pad[2]);
        ay = pad_direction(pad[1], pad[0]);
        if (ax != prev_axis_x)
        begin
            prev_axis_x = ax;
            batch.push_back(make_event(iseg_pkg::EV_AXIS, 16'sd0, 16'sd0, 17'sd0, 17'sd0,
                3'd0, 8'd0, axis_amount(ax)));
        end
        if (ay != prev_axis_y)
        begin
            prev_axis_y = ay;
            batch.push_back(make_event(iseg_pkg::EV_AXIS, 16'sd0, 16'sd0, 17'sd0, 17'sd0,
                3'd0, 8'd1, axis_amount(ay)));
        end

        // keyboard flag drops key edges but the pad history still advances
        if (!osk)
        begin
            for (int i = 0; i < iseg_pkg::KEY_BUTTONS_DEFAULT; i++)
            begin
                if (pad[4 + i] && !prev_pad[4 + i])
                begin
                    batch.push_back(make_event(iseg_pkg::EV_KEY_DOWN, 16'sd0, 16'sd0,
                        17'sd0, 17'sd0, 3'd0, key_codes[i], 16'sd0));
                end
                else if (!pad[4 + i] && prev_pad[4 + i])
                begin
                    batch.push_back(make_event(iseg_pkg::EV_KEY_UP, 16'sd0, 16'sd0,
                        17'sd0, 17'sd0, 3'd0, key_codes[i], 16'sd0));
                end
            end
        end
        prev_pad = pad;

        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[i])
        begin
            expected_events.push_back(batch[i]);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        input_event_t ev;
        if (!rst_n)
        begin
            expected_events.delete();
            key_codes   = iseg_pkg::KEY_MAP_RESET;
            prev_x      = '0;
            prev_y      = '0;
            prev_mask   = '0;
            prev_axis_x = iseg_pkg::AXIS_CENTER;
            prev_axis_y = iseg_pkg::AXIS_CENTER;
            prev_pad    = '0;
            err_count   = 0;
            pending    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("event of kind %0d arrived with none predicted", m_tuser);
                    err_count++;
                end
                else
                begin
                    ev = expected_events.pop_front();
                    compare_field("event_kind", ev.kind, m_tuser);
                    compare_field("pos_x", ev.pos_x, $signed(m_tdata[15:0]));
                    compare_field("pos_y", ev.pos_y, $signed(m_tdata[31:16]));
                    compare_field("rel_x", ev.rel_x, $signed(m_tdata[48:32]));
                    compare_field("rel_y", ev.rel_y, $signed(m_tdata[65:49]));
                    compare_field("button_mask", ev.mask, m_tdata[68:66]);
                    compare_field("which", ev.which, m_tdata[76:69]);
                    compare_field("amount", ev.amount, $signed(m_tdata[92:77]));
                    compare_field("last", ev.last, m_tlast);
                end
            end
            if (cfg_we && cfg_index < iseg_pkg::NUM_KEY_REGS)
            begin
                key_codes[cfg_index] = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                predict_sample(s_tdata);
            end
            pending <= expected_events.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives frame samples and keymap writes into the input sample event
// generator; the checker beside it predicts and compares the events.
// A directed pass covers field extremes, every event kind, cancelling pad
// directions, the keyboard flag and a full thirteen-event sample; random
// phases follow under several keymaps, stalling both channels in all but one.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // mouse_x, mouse_y, mouse_buttons, wheel_delta, pad_bits, osk_active
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // pos_x, pos_y, rel_x, rel_y, button_mask, which, amount
    logic [95:0] m_tdata;
    // event_kind
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [iseg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [iseg_pkg::KEY_CODE_W-1:0] cfg_data = '0;

    int          err_count;
    int          pending;
    int          quiet_cycles = 0;
    logic        no_gaps = 1'b0;

    logic [15:0] last_x = '0;
    logic [15:0] last_y = '0;
    logic [2:0]  last_buttons = '0;
    logic [9:0]  last_pad = '0;

    always #5 clk = ~clk;

    input_sample_event_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    iseg_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .err_count (err_count),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        m_tready <= no_gaps || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("tb_top: errors");
        $finish;
    end

    // hold valid across back-to-back items; drop it only for a gap
    task automatic apply_sample(
        input logic [15:0] x,
        input logic [15:0] y,
        input logic [2:0]  buttons,
        input logic [7:0]  wheel,
        input logic [9:0]  pad,
        input logic        osk
    );
        while (!no_gaps && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, osk, pad, wheel, buttons, y, x};
        last_x       = x;
        last_y       = y;
        last_buttons = buttons;
        last_pad     = pad;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // wait out every predicted event, then let a sample with no event finish
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_keymap(input logic [7:0] codes[iseg_pkg::NUM_KEY_REGS]);
        cfg_we <= 1'b1;
        // indexes past the keymap must be ignored
        for (int i = 0; i < (1 << iseg_pkg::CFG_IDX_W); i++)
        begin
            cfg_index <= i[iseg_pkg::CFG_IDX_W-1:0];
            cfg_data  <= (i < iseg_pkg::NUM_KEY_REGS) ? codes[i] : 8'($urandom());
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_coord(input logic [15:0] prev);
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        end
        else if (r < 65)
        begin
            return prev + 16'($urandom_range(64)) - 16'd32;
        end
        return 16'($urandom());
    endfunction

    task automatic random_samples(input int count);
        logic [15:0] x;
        logic [15:0] y;
        logic [2:0]  buttons;
        logic [7:0]  wheel;
        logic [9:0]  pad;
        int          r;
        int          k;
        for (int n = 0; n < count; n++)
        begin
            x = last_x;
            y = last_y;
            if ($urandom_range(99) >= 30)
            begin
                x = pick_coord(last_x);
                y = pick_coord(last_y);
            end
            buttons = ($urandom_range(99) < 60) ? last_buttons : 3'($urandom());
            wheel   = ($urandom_range(99) < 70) ? 8'd0 : 8'($urandom());
            r = $urandom_range(99);
            pad = last_pad;
            if (r < 40)
            begin
                // flip a single pad bit
                k = $urandom_range(9);
                pad[k] = ~pad[k];
            end
            else if (r < 60)
            begin
                pad = 10'($urandom());
            end
            apply_sample(x, y, buttons, wheel, pad, $urandom_range(99) < 15);
        end
    endtask

    initial
    begin
        logic [7:0] codes[iseg_pkg::NUM_KEY_REGS];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass, default keymap
        apply_sample(16'h0000, 16'h0000, 3'd0, 8'h00, 10'h000, 1'b0); // no change at all
        apply_sample(16'h7FFF, 16'h8000, 3'd0, 8'h00, 10'h000, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd0, 8'h00, 10'h000, 1'b0); // widest deltas
        apply_sample(16'h8000, 16'h7FFF, 3'd7, 8'h7F, 10'h000, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd0, 8'h80, 10'h000, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd1, 8'h00, 10'h000, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd4, 8'h00, 10'h000, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h000, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h003, 1'b0); // up and down cancel
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h001, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h00C, 1'b0); // left and right cancel
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h008, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h004, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h3F0, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h000, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h3F0, 1'b1); // keyboard flag holds keys
        apply_sample(16'h8000, 16'h7FFF, 3'd2, 8'h00, 10'h3F0, 1'b0);
        apply_sample(16'h8000, 16'h7FFF, 3'd0, 8'h00, 10'h000, 1'b1);
        apply_sample(16'd100, -16'sd100, 3'd7, 8'h01, 10'h3FA, 1'b0); // every event at once
        apply_sample(16'd100, -16'sd100, 3'd7, 8'h00, 10'h3FA, 1'b0);
        random_samples(30);
        drain;

        foreach (codes[i])
        begin
            codes[i] = 8'h00;
        end
        program_keymap(codes);
        no_gaps = 1'b1;
        random_samples(50);
        drain;
        no_gaps = 1'b0;

        foreach (codes[i])
        begin
            codes[i] = 8'hFF;
        end
        program_keymap(codes);
        random_samples(50);
        drain;

        foreach (codes[i])
        begin
            codes[i] = 8'($urandom());
        end
        program_keymap(codes);
        random_samples(30);
        drain;

        if (err_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

@@ input_sample_event_generator.f @@
rtl/iseg_pkg.sv
rtl/iseg_detect.sv
rtl/iseg_emit.sv
rtl/input_sample_event_generator.sv
verif/iseg_checker.sv
verif/tb_top.sv
